// ===== src/ppfs_pkg.sv =====
// Shared types and constants for the priority periodic flag scheduler.
package ppfs_pkg;

  localparam int NumChan      = 9;
  localparam int TickW        = 32;
  localparam int BaseTickRate = 1000;

  typedef logic [TickW-1:0]   tick_t;
  typedef logic [NumChan-1:0] flags_t;

  localparam logic ModeInit = 1'b0;
  localparam logic ModePoll = 1'b1;

  // period in ticks, never below one
  localparam tick_t ChanPeriod [NumChan] = '{
    tick_t'((BaseTickRate / 1000 == 0) ? 1 : BaseTickRate / 1000),
    tick_t'((BaseTickRate / 500  == 0) ? 1 : BaseTickRate / 500),
    tick_t'((BaseTickRate / 250  == 0) ? 1 : BaseTickRate / 250),
    tick_t'((BaseTickRate / 100  == 0) ? 1 : BaseTickRate / 100),
    tick_t'((BaseTickRate / 50   == 0) ? 1 : BaseTickRate / 50),
    tick_t'((BaseTickRate / 20   == 0) ? 1 : BaseTickRate / 20),
    tick_t'((BaseTickRate / 10   == 0) ? 1 : BaseTickRate / 10),
    tick_t'((BaseTickRate / 4    == 0) ? 1 : BaseTickRate / 4),
    tick_t'((BaseTickRate / 1    == 0) ? 1 : BaseTickRate / 1)
  };

  // update command from the control stage to the due-tick bank
  typedef struct packed {
    logic   load;
    logic   adv;
    tick_t  now;
    flags_t fire;
  } bank_cmd_t;

endpackage

// ===== src/ppfs_due_bank.sv =====
// Due-tick registers with one wrapping subtract-compare per channel.
module ppfs_due_bank (
  input  logic                clk,
  input  logic                rst,
  input  ppfs_pkg::tick_t     now_tick,
  input  ppfs_pkg::bank_cmd_t cmd,
  output ppfs_pkg::flags_t    due
);

  ppfs_pkg::tick_t due_tick [ppfs_pkg::NumChan];

  always_comb begin
    for (int i = 0; i < ppfs_pkg::NumChan; i++) begin
      due[i] = (ppfs_pkg::tick_t'(now_tick - due_tick[i]) >= ppfs_pkg::ChanPeriod[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ppfs_pkg::NumChan; i++) begin
      if (rst) begin
        due_tick[i] <= '0;
      end else if (cmd.load) begin
        due_tick[i] <= cmd.now;
      end else if (cmd.adv && cmd.fire[i]) begin
        due_tick[i] <= due_tick[i] + ppfs_pkg::ChanPeriod[i];
      end
    end
  end

endmodule

// ===== src/ppfs_prio.sv =====
// Fixed-priority one-hot pick, lowest index wins.
module ppfs_prio (
  input  ppfs_pkg::flags_t req,
  output ppfs_pkg::flags_t grant
);

  ppfs_pkg::flags_t lower;

  always_comb begin
    lower[0] = 1'b0;
    for (int i = 1; i < ppfs_pkg::NumChan; i++) begin
      lower[i] = lower[i-1] | req[i-1];
    end
    grant = req & ~lower;
  end

endmodule

// ===== src/priority_periodic_flag_scheduler.sv =====
// Top level: input register, due-tick bank, priority pick and result register.
//
//   channel | signals                         | transfer when
//   --------+---------------------------------+---------------------
//   in      | in_valid in_ready mode now_tick | in_valid & in_ready
//   out     | out_valid out_ready fire_flags  | out_valid & out_ready
//
// One item per clock while the result is not stalled; each item passes
// through the input register and then the result register. The whole poll
// (nine compares, priority pick, due-tick update) lies between those two.
// Synchronous reset clears valids and all due-ticks to zero.
// A stalled result holds the pipe; in_ready stays high while the input
// register is empty or the result register is empty or being taken.
module priority_periodic_flag_scheduler (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  ppfs_pkg::tick_t        now_tick,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ppfs_pkg::flags_t       fire_flags
);

  logic                s1_valid;
  logic                s1_mode;
  ppfs_pkg::tick_t     s1_now;
  logic                advance;
  logic                go;
  ppfs_pkg::flags_t    due;
  ppfs_pkg::flags_t    grant;
  ppfs_pkg::bank_cmd_t cmd;

  assign advance  = !out_valid || out_ready;
  assign go       = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode <= mode;
      s1_now  <= now_tick;
    end
  end

  ppfs_prio u_prio (
    .req   (due),
    .grant (grant)
  );

  always_comb begin
    cmd.load = go && (s1_mode == ppfs_pkg::ModeInit);
    cmd.adv  = go && (s1_mode == ppfs_pkg::ModePoll);
    cmd.now  = s1_now;
    cmd.fire = grant;
  end

  ppfs_due_bank u_bank (
    .clk      (clk),
    .rst      (rst),
    .now_tick (s1_now),
    .cmd      (cmd),
    .due      (due)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      fire_flags <= (s1_mode == ppfs_pkg::ModePoll) ? grant : '0;
    end
  end

endmodule

// ===== src/ppfs_checker.sv =====
// Port-level checks for the scheduler, bound to the top level.
module ppfs_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input ppfs_pkg::flags_t fire_flags
);

  a_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(fire_flags))
    else $error("more than one channel fired");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fire_flags))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind priority_periodic_flag_scheduler ppfs_checker u_ppfs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .fire_flags (fire_flags)
);
